>>> sv/led_seq_pkg.sv
// ----------------------------------------------------------------------------
// led_seq_pkg
// Shared types and constants of the LED pattern sequencer: item and result
// payloads, opcodes, mode codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package led_seq_pkg;

  // step table size fixed by the register layout
  localparam int unsigned STEPS_MAX         = 8;
  localparam int unsigned DEFAULT_NUM_STEPS = 8;
  localparam int unsigned STEP_IDX_W        = 4;
  localparam int unsigned DUR_W             = 8;
  localparam int unsigned SPAN_W            = 12;
  localparam int unsigned TIME_W            = 32;
  localparam int unsigned CFG_INDEX_W       = 1;
  localparam int unsigned CFG_DATA_W        = 64;

  localparam int unsigned DARK_MS      = 30;
  localparam int unsigned RETRIGGER_MS = 45;
  localparam int unsigned DUR_UNIT_MS  = 10;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_TRAFFIC  = 2'd1;
  localparam logic [1:0] OP_SET_MODE = 2'd2;
  localparam logic [1:0] OP_START    = 2'd3;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_NORMAL   = 2'd1;
  localparam logic [1:0] MODE_SEQUENCE = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LEVELS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_DURATIONS = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        mode_select;
    logic signed [7:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic                  led_on;
    logic                  sequence_running;
    logic [STEP_IDX_W-1:0] current_step;
  } result_t;

endpackage

`default_nettype wire

>>> sv/led_pattern_sequencer.sv
// Throughput: one request per cycle while item_stall is low; all state
// updates in a single pass, and each accepted request registers a result.
// A two-entry output buffer (result register plus skid) lets a request be
// taken while the previous result waits; item_stall rises only when both
// entries are full. Synchronous reset clears all state and the step table.
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// Single LED driver with off, normal (traffic blink) and sequence modes,
// driven by 1 ms ticks, traffic events, mode changes and sequence starts.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_sequencer #(
  parameter int unsigned NUM_STEPS = led_seq_pkg::DEFAULT_NUM_STEPS
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      item_valid,
  output logic                                     item_stall,
  input  wire led_seq_pkg::item_t                  item,
  output logic                                     result_valid,
  input  wire                                      result_stall,
  output led_seq_pkg::result_t                     result,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire [led_seq_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire [led_seq_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import led_seq_pkg::*;

  // config registers
  logic [STEPS_MAX-1:0]       step_levels;
  logic [STEPS_MAX*DUR_W-1:0] step_durations;

  // sequencer state
  logic [TIME_W-1:0]     time_ms, time_ms_next;
  logic [TIME_W-1:0]     dark_until, dark_until_next;
  logic [TIME_W-1:0]     retrigger_after, retrigger_after_next;
  logic [1:0]            active_mode, active_mode_next;
  logic                  seq_active, seq_active_next;
  logic [STEP_IDX_W-1:0] step_index, step_index_next;
  logic [TIME_W-1:0]     next_change_ms, next_change_ms_next;
  logic [7:0]            repeats_left, repeats_left_next;
  logic                  led_level, led_level_next;

  logic [STEP_IDX_W-1:0] adv_index;
  logic [SPAN_W-1:0]     adv_span;

  // output buffer
  result_t result_next;
  result_t skid;
  logic    skid_valid;
  logic    item_accept;
  logic    result_take;

  function automatic logic [SPAN_W-1:0] step_span(
    input logic [STEPS_MAX*DUR_W-1:0] durs,
    input logic [2:0]                 idx
  );
    logic [DUR_W-1:0] d;
    d = durs[DUR_W*idx +: DUR_W];
    return SPAN_W'(d) * SPAN_W'(DUR_UNIT_MS);
  endfunction

  assign cfg_ready   = 1'b1;
  assign item_stall  = skid_valid;
  assign item_accept = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_levels    <= '0;
      step_durations <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_LEVELS:    step_levels    <= cfg_data[STEPS_MAX-1:0];
        CFG_STEP_DURATIONS: step_durations <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_comb begin
    time_ms_next         = time_ms;
    dark_until_next      = dark_until;
    retrigger_after_next = retrigger_after;
    active_mode_next     = active_mode;
    seq_active_next      = seq_active;
    step_index_next      = step_index;
    next_change_ms_next  = next_change_ms;
    repeats_left_next    = repeats_left;
    led_level_next       = led_level;
    adv_index            = '0;
    adv_span             = '0;

    case (item.opcode)
      OP_TICK: time_ms_next = time_ms + TIME_W'(1);
      OP_TRAFFIC: begin
        if (retrigger_after < time_ms && dark_until < time_ms) begin
          dark_until_next      = time_ms + TIME_W'(DARK_MS);
          retrigger_after_next = time_ms + TIME_W'(RETRIGGER_MS);
        end
      end
      OP_SET_MODE: active_mode_next = item.mode_select;
      default: begin
        active_mode_next    = MODE_SEQUENCE;
        seq_active_next     = 1'b1;
        repeats_left_next   = $unsigned(item.repeat_count);
        step_index_next     = '0;
        led_level_next      = step_levels[0];
        next_change_ms_next = time_ms + TIME_W'(step_span(step_durations, 3'd0));
      end
    endcase

    // led update at the current time
    unique case (active_mode_next)
      MODE_NORMAL: led_level_next = (dark_until_next < time_ms_next);
      MODE_SEQUENCE: begin
        if (seq_active_next && time_ms_next > next_change_ms_next) begin
          // a step past the table end acts as the terminator
          adv_index = (step_index_next >= STEP_IDX_W'(NUM_STEPS)) ?
                      STEP_IDX_W'(NUM_STEPS) : step_index_next + STEP_IDX_W'(1);
          step_index_next = adv_index;
          if (adv_index < STEP_IDX_W'(NUM_STEPS)) begin
            led_level_next = step_levels[adv_index[2:0]];
            adv_span       = step_span(step_durations, adv_index[2:0]);
          end
          next_change_ms_next = time_ms_next + TIME_W'(adv_span);
          if (adv_span == '0) begin
            if (repeats_left_next != '0) begin
              // negative count repeats forever
              if (!repeats_left_next[7]) begin
                repeats_left_next = repeats_left_next - 8'd1;
              end
              step_index_next     = '0;
              led_level_next      = step_levels[0];
              next_change_ms_next = time_ms_next +
                                    TIME_W'(step_span(step_durations, 3'd0));
            end else begin
              seq_active_next = 1'b0;
            end
          end
        end
      end
      default: led_level_next = 1'b0;
    endcase

    result_next = '{led_on:           led_level_next,
                    sequence_running: seq_active_next,
                    current_step:     step_index_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms         <= '0;
      dark_until      <= '0;
      retrigger_after <= '0;
      active_mode     <= MODE_OFF;
      seq_active      <= 1'b0;
      step_index      <= '0;
      next_change_ms  <= '0;
      repeats_left    <= '0;
      led_level       <= 1'b0;
    end else if (item_accept) begin
      time_ms         <= time_ms_next;
      dark_until      <= dark_until_next;
      retrigger_after <= retrigger_after_next;
      active_mode     <= active_mode_next;
      seq_active      <= seq_active_next;
      step_index      <= step_index_next;
      next_change_ms  <= next_change_ms_next;
      repeats_left    <= repeats_left_next;
      led_level       <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        result       <= skid;
        skid_valid   <= 1'b0;
      end
    end else if (item_accept) begin
      if (!result_valid || result_take) begin
        result       <= result_next;
        result_valid <= 1'b1;
      end else begin
        skid         <= result_next;
        skid_valid   <= 1'b1;
      end
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  a_skid_needs_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a pending result");

  a_reset_clears_buffer: assert property (@(posedge clk)
    rst |=> !result_valid && !skid_valid)
    else $error("output buffer not cleared by reset");

  a_blocked_goes_to_skid: assert property (@(posedge clk) disable iff (rst)
    item_accept && result_valid && result_stall |=> skid_valid)
    else $error("request accepted under a stalled result was not buffered");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    step_index <= STEP_IDX_W'(NUM_STEPS))
    else $error("step index beyond the table terminator");

  a_off_is_dark: assert property (@(posedge clk) disable iff (rst)
    (active_mode == MODE_OFF || active_mode == MODE_UNUSED) |-> !led_level)
    else $error("led lit in off mode");

endmodule

`default_nettype wire
